// ===== rtl/core/ue2u_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, character codes and helper functions for the escape decoder.
// No dependencies; compiled first.
package ue2u_pkg;

	localparam logic [7:0] CH_BSL = 8'h5C; // backslash
	localparam logic [7:0] CH_U   = 8'h75; // lowercase u

	localparam logic [15:0] CP_TWO   = 16'h0080; // first code that needs two octets
	localparam logic [15:0] CP_THREE = 16'h0800; // first code that needs three octets

	localparam logic [7:0] LEAD2    = 8'hC0;
	localparam logic [7:0] LEAD3    = 8'hE0;
	localparam logic [7:0] CONT     = 8'h80;

	localparam logic [2:0] DIGITS_MAX = 3'd4;

	// escape tracking, one-hot
	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_HELD   = 3'b010,
		PH_DIGITS = 3'b100
	} phase_t;

	// up to four output bytes caused by one item
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      cnt;
	} grp_t;

	// decoder state carried from item to item
	typedef struct packed {
		phase_t      phase;
		logic [15:0] accum;
		logic [2:0]  count;
	} esc_state_t;

	function automatic grp_t grp_push(input grp_t g, input logic [7:0] b);
		grp_t r;
		r = g;
		r.bytes[g.cnt[1:0]] = b;
		r.cnt = g.cnt + 3'd1;
		return r;
	endfunction

	function automatic grp_t grp_push_code(input grp_t g, input logic [15:0] cp);
		grp_t r;
		r = g;
		if (cp < CP_TWO) begin
			r = grp_push(r, cp[7:0]);
		end else if (cp < CP_THREE) begin
			r = grp_push(r, LEAD2 | {3'b000, cp[10:6]});
			r = grp_push(r, CONT | {2'b00, cp[5:0]});
		end else begin
			r = grp_push(r, LEAD3 | {4'b0000, cp[15:12]});
			r = grp_push(r, CONT | {2'b00, cp[11:6]});
			r = grp_push(r, CONT | {2'b00, cp[5:0]});
		end
		return r;
	endfunction

	function automatic logic hex_ok(input logic [7:0] b);
		return ((b >= 8'h30) && (b <= 8'h39)) ||
		       ((b >= 8'h61) && (b <= 8'h66)) ||
		       ((b >= 8'h41) && (b <= 8'h46));
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] b);
		logic [7:0] v;
		if (b <= 8'h39) begin
			v = b - 8'h30;
		end else if (b >= 8'h61) begin
			v = b - 8'h57;
		end else begin
			v = b - 8'h37;
		end
		return v[3:0];
	endfunction

endpackage

// ===== rtl/core/ue2u_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the escape decoder: raw text bytes with an end mark.
// No dependencies.
interface ue2u_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== rtl/core/ue2u_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the escape decoder: decoded bytes with run and text marks.
// No dependencies.
interface ue2u_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       text_end;

	modport source (output valid, output out_byte, output run_last, output text_end,
		input ready);
	modport sink   (input valid, input out_byte, input run_last, input text_end,
		output ready);
endinterface

// ===== rtl/core/ue2u_step.sv =====
`timescale 1ns / 1ps
// Combinational decode of one byte: next escape state and the bytes it releases.
// Depends on ue2u_pkg.
module ue2u_step (
	input  ue2u_pkg::esc_state_t cur,
	input  logic [7:0]           in_byte,
	input  logic                 in_last,
	output ue2u_pkg::esc_state_t nxt,
	output ue2u_pkg::grp_t       grp
);
	import ue2u_pkg::*;

	always_comb begin
		logic [15:0] acc_n;
		logic [2:0]  cnt_n;
		esc_state_t  s;
		grp_t        g;

		s = cur;
		g = '0;
		acc_n = {cur.accum[11:0], hex_val(in_byte)};
		cnt_n = cur.count + 3'd1;

		case (cur.phase)
			PH_HELD: begin
				if (in_byte == CH_U) begin
					s.phase = PH_DIGITS;
					s.accum = '0;
					s.count = '0;
				end else begin
					g = grp_push(g, CH_BSL);
					if (in_byte == CH_BSL) begin
						s.phase = PH_HELD;
					end else begin
						s.phase = PH_IDLE;
						g = grp_push(g, in_byte);
					end
				end
			end
			PH_DIGITS: begin
				if (hex_ok(in_byte) && (cur.count < DIGITS_MAX)) begin
					s.accum = acc_n;
					s.count = cnt_n;
					if (cnt_n >= DIGITS_MAX) begin
						g = grp_push_code(g, acc_n);
						s.phase = PH_IDLE;
						s.accum = '0;
						s.count = '0;
					end
				end else begin
					// flush collected digits, then treat the byte as plain text
					if (cur.count != 3'd0) begin
						g = grp_push_code(g, cur.accum);
					end
					s.accum = '0;
					s.count = '0;
					if (in_byte == CH_BSL) begin
						s.phase = PH_HELD;
					end else begin
						s.phase = PH_IDLE;
						g = grp_push(g, in_byte);
					end
				end
			end
			default: begin
				if (in_byte == CH_BSL) begin
					s.phase = PH_HELD;
				end else begin
					s.phase = PH_IDLE;
					g = grp_push(g, in_byte);
				end
			end
		endcase

		if (in_last) begin
			if (s.phase == PH_HELD) begin
				g = grp_push(g, CH_BSL);
			end else if ((s.phase == PH_DIGITS) && (s.count != 3'd0)) begin
				g = grp_push_code(g, s.accum);
			end
			s.phase = PH_IDLE;
			s.accum = '0;
			s.count = '0;
		end

		nxt = s;
		grp = g;
	end

endmodule

// ===== rtl/core/unicode_escape_to_utf8_unit.sv =====
`timescale 1ns / 1ps
// Top level of the escape decoder: input register, decode step, output byte queue.
// Depends on ue2u_pkg, ue2u_in_if, ue2u_out_if and ue2u_step.
//
//   channel   dir  payload                          handshake
//   in_ch     in   in_byte[7:0], in_last            valid/ready
//   out_ch    out  out_byte[7:0], run_last, text_end valid/ready
//
// One item per cycle enters the input register while in_ch.ready is high; the decode
// step runs combinationally between the input register and the byte group register.
// An item yields zero to four bytes, sent one per cycle while out_ch.ready is high.
// Reset (arst_n low) clears the escape state and all valid flags. An output stall holds
// the group; the input register still takes one more item, then in_ch.ready drops until
// the group drains.
module unicode_escape_to_utf8_unit (
	input  logic      clk,
	input  logic      arst_n,
	ue2u_in_if.sink   in_ch,
	ue2u_out_if.source out_ch
);
	import ue2u_pkg::*;

	// input register
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// escape state
	esc_state_t st_q;
	esc_state_t st_nxt;

	// byte group waiting on the output
	grp_t       grp_q;
	logic       grp_vld_q;
	logic       grp_last_q;
	logic [1:0] idx_q;

	grp_t       grp_nxt;
	logic       out_fire;
	logic       grp_done;
	logic       grp_free;
	logic       adv;
	logic [2:0] idx_next;

	ue2u_step u_step (
		.cur     (st_q),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.nxt     (st_nxt),
		.grp     (grp_nxt)
	);

	assign idx_next = {1'b0, idx_q} + 3'd1;
	assign out_fire = grp_vld_q && out_ch.ready;
	assign grp_done = out_fire && (idx_next == grp_q.cnt);
	assign grp_free = !grp_vld_q || grp_done;
	// advance the input register into the decode step once the group slot frees
	assign adv      = vld_s1 && grp_free;

	assign in_ch.ready = !vld_s1 || adv;

	assign out_ch.valid    = grp_vld_q;
	assign out_ch.out_byte = grp_q.bytes[idx_q];
	assign out_ch.run_last = idx_next == grp_q.cnt;
	assign out_ch.text_end = (idx_next == grp_q.cnt) && grp_last_q;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			vld_s1 <= in_ch.valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.in_byte;
			last_s1 <= in_ch.in_last;
		end
	end

	// escape state advances with each decoded item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase <= PH_IDLE;
			st_q.accum <= '0;
			st_q.count <= '0;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	// group control: load a fresh group, step through it, drop it when drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_vld_q <= 1'b0;
			idx_q     <= '0;
		end else if (adv && (grp_nxt.cnt != 3'd0)) begin
			grp_vld_q <= 1'b1;
			idx_q     <= '0;
		end else if (grp_done) begin
			grp_vld_q <= 1'b0;
			idx_q     <= '0;
		end else if (out_fire) begin
			idx_q <= idx_next[1:0];
		end
	end

	// group payload
	always_ff @(posedge clk) begin
		if (adv && (grp_nxt.cnt != 3'd0)) begin
			grp_q      <= grp_nxt;
			grp_last_q <= last_s1;
		end
	end

endmodule

// ===== verif/tb_unicode_escape_to_utf8_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for unicode_escape_to_utf8_unit: directed and random escaped text,
// checked byte by byte against a UTF-8 escape decoder kept in a scoreboard class.
// Depends on ue2u_pkg, ue2u_in_if, ue2u_out_if and the unicode_escape_to_utf8_unit RTL.
module tb_unicode_escape_to_utf8_unit;
	import ue2u_pkg::*;

	localparam int HOLD_CYCLES = 160; // long output stall that forces input backpressure
	localparam int DRAIN_LIMIT = 5000;

	// one decoded byte as it should leave the block
	typedef struct packed {
		logic [7:0] data;
		logic       run_last;
		logic       text_end;
	} utf8_byte_t;

	// one raw text byte as it is offered to the block
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} text_byte_t;

	// Decoder state mirror plus the queue of decoded bytes still owed by the block.
	class utf8_scoreboard;
		phase_t      esc_phase;
		logic [15:0] code_acc;
		logic [2:0]  ndigits;
		utf8_byte_t  owed_q[$];
		utf8_byte_t  step_q[$];
		int          errors;

		function new();
			esc_phase = PH_IDLE;
			code_acc  = '0;
			ndigits   = '0;
			errors    = 0;
		endfunction

		function void note_error(string msg);
			errors++;
			if (errors <= 10)
				$display("ERROR at %0t: %s", $time, msg);
		endfunction

		function int outstanding();
			return owed_q.size();
		endfunction

		function void emit_byte(logic [7:0] b);
			utf8_byte_t e;
			e.data     = b;
			e.run_last = 1'b0;
			e.text_end = 1'b0;
			step_q.insert(step_q.size(), e);
		endfunction

		function void emit_code(logic [15:0] cp);
			if (cp < CP_TWO) begin
				emit_byte(cp[7:0]);
			end else if (cp < CP_THREE) begin
				emit_byte(LEAD2 | {3'b000, cp[10:6]});
				emit_byte(CONT | {2'b00, cp[5:0]});
			end else begin
				emit_byte(LEAD3 | {4'b0000, cp[15:12]});
				emit_byte(CONT | {2'b00, cp[11:6]});
				emit_byte(CONT | {2'b00, cp[5:0]});
			end
		endfunction

		function int digit_value(logic [7:0] b);
			if (b >= "0" && b <= "9") return int'(b) - int'("0");
			if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
			if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
			return -1;
		endfunction

		// ordinary byte: a backslash is held for lookahead, anything else goes out
		function void take_plain(logic [7:0] b);
			if (b == CH_BSL) begin
				esc_phase = PH_HELD;
			end else begin
				esc_phase = PH_IDLE;
				emit_byte(b);
			end
		endfunction

		function void note_input(logic [7:0] b, logic last);
			int hv;
			step_q.delete();
			case (esc_phase)
				PH_HELD: begin
					if (b == CH_U) begin
						esc_phase = PH_DIGITS;
						code_acc  = '0;
						ndigits   = '0;
					end else begin
						emit_byte(CH_BSL);
						take_plain(b);
					end
				end
				PH_DIGITS: begin
					hv = digit_value(b);
					if (hv >= 0 && ndigits < DIGITS_MAX) begin
						code_acc = {code_acc[11:0], hv[3:0]};
						ndigits  = ndigits + 3'd1;
						if (ndigits >= DIGITS_MAX) begin
							emit_code(code_acc);
							esc_phase = PH_IDLE;
							code_acc  = '0;
							ndigits   = '0;
						end
					end else begin
						if (ndigits > 0)
							emit_code(code_acc);
						code_acc = '0;
						ndigits  = '0;
						take_plain(b);
					end
				end
				default: take_plain(b);
			endcase
			if (last) begin
				if (esc_phase == PH_HELD)
					emit_byte(CH_BSL);
				else if (esc_phase == PH_DIGITS && ndigits > 0)
					emit_code(code_acc);
				esc_phase = PH_IDLE;
				code_acc  = '0;
				ndigits   = '0;
			end
			if (step_q.size() > 0) begin
				step_q[step_q.size() - 1].run_last = 1'b1;
				step_q[step_q.size() - 1].text_end = last;
			end
			foreach (step_q[i])
				owed_q.insert(owed_q.size(), step_q[i]);
		endfunction

		function void check_result(logic [7:0] b, logic rl, logic te);
			utf8_byte_t e;
			if (owed_q.size() == 0) begin
				note_error($sformatf("unexpected byte %02h run_last %b text_end %b", b, rl, te));
				return;
			end
			e = owed_q.pop_front();
			if (e.data !== b || e.run_last !== rl || e.text_end !== te)
				note_error($sformatf("expected %02h/%b/%b got %02h/%b/%b",
					e.data, e.run_last, e.text_end, b, rl, te));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ue2u_in_if  in_ch();
	ue2u_out_if out_ch();

	unicode_escape_to_utf8_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	utf8_scoreboard sb;
	text_byte_t     feed_q[$];
	bit             tx_steady;  // sender never idles while set
	bit             rx_steady;  // receiver never stalls while set
	int             hold_req_cnt;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hard limit: far beyond the slowest legal run of about 460 items.
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Receiver: stall at random, or hold off for a long counted stretch on request.
	initial begin
		int hold_left;
		int served;
		hold_left    = 0;
		served       = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (served != hold_req_cnt) begin
				served    = hold_req_cnt;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else if (rx_steady) begin
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= 13);
			end
		end
	end

	// Check every byte the block hands over; values here are the ones held at the edge.
	always @(posedge clk) begin
		if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
			sb.check_result(out_ch.out_byte, out_ch.run_last, out_ch.text_end);
	end

	function automatic void put(logic [7:0] b, logic last);
		text_byte_t t;
		t.data = b;
		t.last = last;
		feed_q.insert(feed_q.size(), t);
	endfunction

	function automatic logic [7:0] rand_hex_char();
		int v;
		v = $urandom_range(15);
		if (v < 10)
			return 8'("0" + v);
		return ($urandom_range(1) != 0) ? 8'("a" + v - 10) : 8'("A" + v - 10);
	endfunction

	// Append one text: escapes with one to four random digits for 45 of 100 tokens, the rest
	// plain bytes, broken escapes and stray backslashes. The final byte carries the end mark.
	function automatic void add_random_text();
		int ntok;
		int r;
		int nd;
		ntok = ($urandom_range(9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
		for (int k = 0; k < ntok; k++) begin
			r = $urandom_range(99);
			if (r < 45) begin
				put(CH_BSL, 1'b0);
				put(CH_U, 1'b0);
				nd = $urandom_range(1, 4);
				for (int d = 0; d < nd; d++)
					put(rand_hex_char(), 1'b0);
			end else if (r < 53) begin
				// broken escape: backslash then any byte, uppercase U often
				put(CH_BSL, 1'b0);
				put(($urandom_range(1) != 0) ? 8'("U") : 8'($urandom_range(255)), 1'b0);
			end else if (r < 58) begin
				put(CH_BSL, 1'b0);
				put(CH_BSL, 1'b0);
			end else if (r < 63) begin
				put(CH_BSL, 1'b0);
				put(CH_U, 1'b0);
			end else if (r < 70) begin
				put(rand_hex_char(), 1'b0);
			end else begin
				put(8'($urandom_range(255)), 1'b0);
			end
		end
		feed_q[feed_q.size() - 1].last = 1'b1;
	endfunction

	// Offer every queued byte in order; hold valid across back-to-back items.
	task automatic send_feed();
		text_byte_t t;
		while (feed_q.size() > 0) begin
			t = feed_q.pop_front();
			while (!tx_steady && $urandom_range(99) < 13) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
			end
			in_ch.valid   <= 1'b1;
			in_ch.in_byte <= t.data;
			in_ch.in_last <= t.last;
			do
				@(posedge clk);
			while (in_ch.ready !== 1'b1);
			sb.note_input(t.data, t.last);
		end
	endtask

	// Drop valid and wait for every owed byte to come out.
	task automatic drain_wait();
		int guard;
		guard = 0;
		in_ch.valid <= 1'b0;
		do begin
			@(posedge clk);
			guard++;
		end while (sb.outstanding() != 0 && guard < DRAIN_LIMIT);
	endtask

	initial begin
		sb            = new();
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.in_byte = 8'h00;
		in_ch.in_last = 1'b0;
		tx_steady     = 1'b0;
		rx_steady     = 1'b0;
		hold_req_cnt  = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed text: zero and all-ones bytes, uppercase U after a backslash,
		// backslash after backslash, a one-digit code cut by a non-hex byte,
		// an empty escape, a full four-digit code, a partial code flushed at the end,
		// an empty escape at the end, and a lone backslash at the end.
		put(8'h00, 1'b0);
		put(8'hFF, 1'b0);
		put(CH_BSL, 1'b0); put("U", 1'b0);
		put(CH_BSL, 1'b0); put(CH_BSL, 1'b0); put(CH_U, 1'b0); put("a", 1'b0);
		put("g", 1'b0);
		put(CH_BSL, 1'b0); put(CH_U, 1'b0); put("x", 1'b0);
		put(CH_BSL, 1'b0); put(CH_U, 1'b0);
		put("F", 1'b0); put("f", 1'b0); put("F", 1'b0); put("f", 1'b0);
		put(CH_BSL, 1'b0); put(CH_U, 1'b0); put("7", 1'b0); put("F", 1'b0); put("f", 1'b1);
		put(CH_BSL, 1'b0); put(CH_U, 1'b1);
		put(CH_BSL, 1'b1);
		send_feed();

		// Pause the sender until the block has delivered everything.
		drain_wait();

		// Random text under a long output stall: keep offering so the input backs up.
		hold_req_cnt++;
		while (feed_q.size() < 150)
			add_random_text();
		send_feed();

		// Stretch with no idling on either side.
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		while (feed_q.size() < 120)
			add_random_text();
		send_feed();
		tx_steady = 1'b0;
		rx_steady = 1'b0;

		drain_wait();

		while (feed_q.size() < 170)
			add_random_text();
		send_feed();

		// Let the tail drain, then keep waiting for stray bytes before the final check.
		drain_wait();
		repeat (20) @(posedge clk);
		if (sb.outstanding() != 0)
			sb.note_error($sformatf("%0d expected bytes never arrived", sb.outstanding()));

		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/ue2u_pkg.sv
rtl/core/ue2u_in_if.sv
rtl/core/ue2u_out_if.sv
rtl/core/ue2u_step.sv
rtl/core/unicode_escape_to_utf8_unit.sv
verif/tb_unicode_escape_to_utf8_unit.sv
